// ===== rtl/sem_pkg.sv =====
// Shared types, constants and helpers for the Sobel edge magnitude block.
// Used by sem_root, sobel_edge_magnitude and the testbench; depends on nothing.
`timescale 1ns / 1ps

package sem_pkg;

    // Line store depth; must be a power of two so the column maps onto an address.
    localparam int MAX_LINE   = 4096;
    localparam int HEIGHT_MAX = 4096;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 13;
    localparam int COORD_W = 12;
    localparam int COL_W   = $clog2(MAX_LINE);
    localparam int EW      = COL_W + 1;
    localparam int ROW_W   = $clog2(HEIGHT_MAX);
    localparam int EH      = ROW_W + 1;

    localparam int GRAD_W     = 11;
    localparam int SUM_W      = 2 * GRAD_W;
    localparam int ROOT_V_W   = 16;
    localparam int ROOT_STEPS = 8;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam logic [PIX_W-1:0] SAT_LEVEL = 8'd255;
    localparam int               SAT_SQ    = (int'(SAT_LEVEL) + 1) * (int'(SAT_LEVEL) + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ROOT,
        ST_HOLD
    } t_state;

    typedef enum logic [1:0] {
        RT_IDLE,
        RT_SQUARE,
        RT_STEP,
        RT_DONE
    } t_root_state;

    typedef struct packed {
        logic                     start;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_root_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [PIX_W-1:0] root;
    } t_root_stat;

    function automatic logic [EW-1:0] eff_width(input logic [CFG_W-1:0] w);
        logic [EW-1:0] res;
        if (w < CFG_W'(3)) begin
            res = EW'(3);
        end else if (int'(w) > MAX_LINE) begin
            res = EW'(MAX_LINE);
        end else begin
            res = EW'(w);
        end
        return res;
    endfunction

    function automatic logic [EH-1:0] eff_height(input logic [CFG_W-1:0] h);
        logic [EH-1:0] res;
        if (h < CFG_W'(3)) begin
            res = EH'(3);
        end else if (int'(h) > HEIGHT_MAX) begin
            res = EH'(HEIGHT_MAX);
        end else begin
            res = EH'(h);
        end
        return res;
    endfunction

endpackage

// ===== rtl/sem_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sem_root.sv =====
// Gradient magnitude unit: squares and sums the two gradients, then takes the
// integer square root one root bit per step, saturated. Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_root (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sem_pkg::t_root_req  i_req,
    output sem_pkg::t_root_stat o_stat
);
    import sem_pkg::*;

    t_root_state r_state, n_state;

    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [ROOT_V_W-1:0]      r_v, r_res;
    logic [STEP_W-1:0]        r_step;
    logic                     r_sat;

    logic signed [SUM_W-1:0] w_sq_x, w_sq_y;
    logic [SUM_W-1:0]        w_sum;
    logic                    w_sum_sat;
    logic [ROOT_V_W-1:0]     w_bit, w_trial;
    logic                    w_take;

    assign w_sq_x    = r_gx * r_gx;
    assign w_sq_y    = r_gy * r_gy;
    assign w_sum     = unsigned'(w_sq_x) + unsigned'(w_sq_y);
    assign w_sum_sat = (w_sum >= SUM_W'(SAT_SQ));

    assign w_bit   = ROOT_V_W'(1) << {r_step, 1'b0};
    assign w_trial = r_res + w_bit;
    assign w_take  = (r_v >= w_trial);

    always_comb begin
        n_state = r_state;
        case (r_state)
            RT_IDLE:   if (i_req.start) n_state = RT_SQUARE;
            RT_SQUARE: n_state = w_sum_sat ? RT_DONE : RT_STEP;
            RT_STEP:   if (r_step == '0) n_state = RT_DONE;
            RT_DONE:   n_state = RT_IDLE;
            default:   n_state = RT_IDLE;
        endcase
    end

    always_comb begin
        o_stat.busy = (r_state != RT_IDLE);
        o_stat.done = (r_state == RT_DONE);
        o_stat.root = r_sat ? SAT_LEVEL : r_res[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RT_IDLE: begin
                if (i_req.start) begin
                    r_gx <= i_req.gx;
                    r_gy <= i_req.gy;
                end
            end
            RT_SQUARE: begin
                r_sat  <= w_sum_sat;
                r_v    <= w_sum[ROOT_V_W-1:0];
                r_res  <= '0;
                r_step <= STEP_W'(ROOT_STEPS - 1);
            end
            RT_STEP: begin
                // subtract the trial value when it fits, shift the partial root
                if (w_take) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_step <= r_step - STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
// Sobel 3x3 edge magnitude. Feed 8-bit grayscale pixels in raster order, top-left
// first; for every interior pixel the block returns floor(sqrt(gx^2 + gy^2)),
// saturated at 255, with the centre coordinates and a mark on the last interior
// result of the frame. Border pixels give no result. Frame width (3..4096) and
// height (3..4096) are written through the configuration port; the user must
// write them only while idle, which the block does not enforce. A write restarts
// the frame. Two 4096-entry line stores hold the two rows above. One item is
// worked at a time: a border pixel is accepted, then the line stores are read
// and written back; an interior pixel then passes the square-root unit
// (square-and-sum, eight root steps skipped on saturation, hand-off) and
// loads the output register; it lets the next item enter while a result waits.
`timescale 1ns / 1ps

module sobel_edge_magnitude (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sem_pkg::PIX_W-1:0]         i_pixel_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sem_pkg::PIX_W-1:0]         o_edge_value,
    output logic [sem_pkg::COORD_W-1:0]       o_out_col,
    output logic [sem_pkg::COORD_W-1:0]       o_out_row,
    output logic                              o_frame_last
);
    import sem_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_pix;
    logic [PIX_W-1:0] r_win [6];

    logic [PIX_W-1:0]   r_edge;
    logic [COORD_W-1:0] r_pend_col, r_pend_row;
    logic               r_pend_last;

    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_edge;
    logic [COORD_W-1:0] r_out_col, r_out_row;
    logic               r_out_last;

    logic [EW-1:0]    w_w;
    logic [EH-1:0]    w_h;
    logic             w_wrap;
    logic [COL_W-1:0] w_c;
    logic [ROW_W-1:0] w_r;
    logic [EW-1:0]    w_c_inc;
    logic [EH-1:0]    w_r_inc;
    logic             w_emit, w_last;

    logic [PIX_W-1:0] w_up, w_mid;
    logic signed [GRAD_W-1:0] w_gx, w_gy;
    logic signed [GRAD_W-1:0] s0, s1, s2, s3, s5, s_up, s_mid, s_low;

    logic w_accept, w_cfg_hit, w_out_free;
    logic w_mem_re, w_mem_we, w_load_out, w_start;

    t_root_req  w_req;
    t_root_stat w_stat;

    assign w_accept   = i_valid && o_ready;
    assign w_cfg_hit  = i_cfg_wr_en &&
                        (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);
    assign w_out_free = !r_out_valid || i_ready;

    // frame geometry; counters outside the frame restart it
    assign w_w    = eff_width(r_frame_width);
    assign w_h    = eff_height(r_frame_height);
    assign w_wrap = (EW'(r_col) >= w_w) || (EH'(r_row) >= w_h);
    assign w_c    = w_wrap ? '0 : r_col;
    assign w_r    = w_wrap ? '0 : r_row;

    assign w_c_inc = EW'(w_c) + EW'(1);
    assign w_r_inc = EH'(w_r) + EH'(1);
    assign w_emit  = (w_c >= COL_W'(2)) && (w_r >= ROW_W'(2));
    assign w_last  = (EW'(w_c) == w_w - EW'(1)) && (EH'(w_r) == w_h - EH'(1));

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_c),
        .i_wdata (w_mid),
        .i_re    (w_mem_re),
        .i_raddr (w_c),
        .o_rdata (w_up)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_c),
        .i_wdata (r_pix),
        .i_re    (w_mem_re),
        .i_raddr (w_c),
        .o_rdata (w_mid)
    );

    assign s0    = $signed(GRAD_W'(r_win[0]));
    assign s1    = $signed(GRAD_W'(r_win[1]));
    assign s2    = $signed(GRAD_W'(r_win[2]));
    assign s3    = $signed(GRAD_W'(r_win[3]));
    assign s5    = $signed(GRAD_W'(r_win[5]));
    assign s_up  = $signed(GRAD_W'(w_up));
    assign s_mid = $signed(GRAD_W'(w_mid));
    assign s_low = $signed(GRAD_W'(r_pix));

    assign w_gx = s_up + (s_mid <<< 1) + s_low - s0 - (s1 <<< 1) - s2;
    assign w_gy = s2 + (s5 <<< 1) + s_low - s0 - (s3 <<< 1) - s_up;

    assign w_req.start = w_start;
    assign w_req.gx    = w_gx;
    assign w_req.gy    = w_gy;

    sem_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_READ;
            ST_READ: n_state = w_emit ? ST_ROOT : ST_IDLE;
            ST_ROOT: if (w_stat.done) n_state = ST_HOLD;
            ST_HOLD: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        w_mem_re   = (r_state == ST_IDLE) && i_valid;
        w_mem_we   = (r_state == ST_READ);
        w_start    = (r_state == ST_READ) && w_emit;
        w_load_out = (r_state == ST_HOLD) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en && i_cfg_index == REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_wdata;
            end
            if (i_cfg_wr_en && i_cfg_index == REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_wdata;
            end

            if (w_cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_state == ST_READ) begin
                // advance raster position, wrap at end of row and frame
                if (w_c_inc >= w_w) begin
                    r_col <= '0;
                    r_row <= (w_r_inc >= w_h) ? '0 : w_r_inc[ROW_W-1:0];
                end else begin
                    r_col <= w_c_inc[COL_W-1:0];
                end
            end

            if (r_state == ST_READ) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= w_up;
                r_win[4] <= w_mid;
                r_win[5] <= r_pix;
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix <= i_pixel_in;
        end
        if (r_state == ST_READ) begin
            r_pend_col  <= COORD_W'(w_c - COL_W'(1));
            r_pend_row  <= COORD_W'(w_r - ROW_W'(1));
            r_pend_last <= w_last;
        end
        if (r_state == ST_ROOT && w_stat.done) begin
            r_edge <= w_stat.root;
        end
        if (w_load_out) begin
            r_out_edge <= r_edge;
            r_out_col  <= r_pend_col;
            r_out_row  <= r_pend_row;
            r_out_last <= r_pend_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_value = r_out_edge;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_frame_last = r_out_last;

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_READ)
        else $error("accepted item did not move to line store read");

    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_state == ST_ROOT)
        else $error("root unit finished outside the wait state");

    a_idle_root_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_stat.busy)
        else $error("new item offered while root unit is busy");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_col != '0 && o_out_row != '0))
        else $error("result reported for a border pixel");

endmodule

// ===== verif/tb_sobel_edge_magnitude.sv =====
// Self-checking testbench for sobel_edge_magnitude: pixel frames in, edge magnitudes out,
// checked against a cycle-free Sobel window model kept in this file.
// Depends on rtl/sem_pkg.sv and rtl/sobel_edge_magnitude.sv.
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;

    import sem_pkg::*;

    localparam int SETTLE_CYCLES    = 20;
    localparam int DIR_ROWS         = 31;
    localparam int LONG_HOLD_CYCLES = 400;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]   magnitude;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               frame_end;
    } t_edge_result;

    typedef enum logic {
        ROW_CFG,
        ROW_PIX
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      val;
        logic                  typed;
        logic [PIX_W-1:0]      mag;
    } t_dir_row;

    localparam t_edge_result NO_EDGE = '0;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [PIX_W-1:0]     i_pixel_in  = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [PIX_W-1:0]     o_edge_value;
    logic [COORD_W-1:0]   o_out_col;
    logic [COORD_W-1:0]   o_out_row;
    logic                 o_frame_last;

    // window model state
    bit [PIX_W-1:0] upper_line  [MAX_LINE];
    bit [PIX_W-1:0] middle_line [MAX_LINE];
    int             win_pix [6];   // 0..2 left column, 3..5 centre column; top to bottom
    int unsigned    col_pos;
    int unsigned    row_pos;
    logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;

    t_edge_result pending_edges [$];
    t_edge_result head_edge;
    int           error_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    bit           hold_req       = 1'b0;
    bit           hold_seen      = 1'b0;
    int           hold_cycles    = 0;

    // every typed row closes a 3x3 frame
    t_dir_row dir_table [0:DIR_ROWS-1] = '{
        '{ROW_CFG, REG_FRAME_WIDTH,  13'd0,    1'b0, 8'd0},
        '{ROW_CFG, REG_FRAME_HEIGHT, 13'd2,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b1, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd255,  1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd255,  1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd255,  1'b1, 8'd255},
        '{ROW_PIX, '0,               13'd255,  1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd255,  1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd255,  1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_CFG, REG_SPARE_A,      13'h1FFF, 1'b0, 8'd0},
        '{ROW_CFG, REG_SPARE_B,      13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b0, 8'd0},
        '{ROW_PIX, '0,               13'd0,    1'b1, 8'd255}
    };

    sobel_edge_magnitude dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_edge_value (o_edge_value),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned active_extent(input logic [CFG_W-1:0] v,
                                                  input int unsigned top);
        if (v < 3) begin
            return 3;
        end else if (v > top) begin
            return top;
        end
        return v;
    endfunction

    // bitwise root search; tops out at 255, which is the saturation
    function automatic logic [PIX_W-1:0] gradient_magnitude(input int unsigned sum);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = PIX_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sum) begin
                root = trial;
            end
        end
        return PIX_W'(root);
    endfunction

    task automatic window_step(input logic [PIX_W-1:0] pix, output bit produced,
                               output t_edge_result res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int up;
        int mid;
        int low;
        int gx;
        int gy;
        w = active_extent(width_reg, MAX_LINE);
        h = active_extent(height_reg, HEIGHT_MAX);
        c = col_pos;
        r = row_pos;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        up  = upper_line[c];
        mid = middle_line[c];
        low = pix;
        produced = (c >= 2 && r >= 2);
        res = '0;
        if (produced) begin
            gx = up + 2 * mid + low - win_pix[0] - 2 * win_pix[1] - win_pix[2];
            gy = win_pix[2] + 2 * win_pix[5] + low - win_pix[0] - 2 * win_pix[3] - up;
            res.magnitude = gradient_magnitude(gx * gx + gy * gy);
            res.col       = COORD_W'(c - 1);
            res.row       = COORD_W'(r - 1);
            res.frame_end = (c == w - 1 && r == h - 1);
        end
        win_pix[0] = win_pix[3];
        win_pix[1] = win_pix[4];
        win_pix[2] = win_pix[5];
        win_pix[3] = up;
        win_pix[4] = mid;
        win_pix[5] = low;
        upper_line[c]  = PIX_W'(mid);
        middle_line[c] = PIX_W'(low);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ns ERROR %s", $realtime, msg);
    endtask

    task automatic offer_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                               input t_edge_result typed_res);
        bit           produced;
        t_edge_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        window_step(pix, produced, predicted);
        if (typed) begin
            pending_edges.push_back(typed_res);
        end else if (produced) begin
            pending_edges.push_back(predicted);
        end
    endtask

    // drop valid, drain all results, then cover any border item still in flight
    task automatic settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = val;
            end else begin
                height_reg = val;
            end
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int style, input int base);
        int v;
        case (style)
            0: return PIX_W'($urandom_range(255));
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            default: begin
                v = base + int'($urandom_range(8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PIX_W'(v);
            end
        endcase
    endfunction

    // receiver: one long hold on request, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen   <= 1'b1;
            hold_cycles <= LONG_HOLD_CYCLES - 1;
            i_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_edges.size() == 0) begin
                report_error($sformatf("result with nothing expected at col %0d row %0d",
                                       o_out_col, o_out_row));
            end else begin
                head_edge = pending_edges.pop_front();
                if (o_edge_value !== head_edge.magnitude)
                    report_error($sformatf("edge_value at (%0d,%0d): got %0d, expected %0d",
                                           head_edge.col, head_edge.row, o_edge_value,
                                           head_edge.magnitude));
                if (o_out_col !== head_edge.col)
                    report_error($sformatf("out_col: got %0d, expected %0d",
                                           o_out_col, head_edge.col));
                if (o_out_row !== head_edge.row)
                    report_error($sformatf("out_row: got %0d, expected %0d",
                                           o_out_row, head_edge.row));
                if (o_frame_last !== head_edge.frame_end)
                    report_error($sformatf("frame_last at (%0d,%0d): got %0b, expected %0b",
                                           head_edge.col, head_edge.row, o_frame_last,
                                           head_edge.frame_end));
            end
        end
    end

    initial begin
        t_edge_result     typed_res;
        int               n_items;
        int               style;
        int               base;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;

        typed_res = '{magnitude: '0, col: COORD_W'(1), row: COORD_W'(1), frame_end: 1'b1};
        style = 0;
        base  = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry 640x480: the start of the first row gives no results
        for (int k = 0; k < 64; k++) offer_pixel(PIX_W'($urandom_range(255)), 1'b0, NO_EDGE);

        foreach (dir_table[k]) begin
            if (dir_table[k].kind == ROW_CFG) begin
                settle_block();
                write_reg(dir_table[k].idx, dir_table[k].val);
            end else begin
                typed_res.magnitude = dir_table[k].mag;
                offer_pixel(dir_table[k].val[PIX_W-1:0], dir_table[k].typed, typed_res);
            end
        end

        // widest and tallest frames; oversize values saturate to 4096
        settle_block();
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (int k = 0; k < 40; k++) offer_pixel(PIX_W'($urandom_range(255)), 1'b0, NO_EDGE);
        settle_block();
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        for (int k = 0; k < 60; k++) offer_pixel(PIX_W'($urandom_range(255)), 1'b0, NO_EDGE);
        settle_block();
        write_reg(REG_FRAME_WIDTH, 13'd4096);
        write_reg(REG_FRAME_HEIGHT, 13'd4096);
        for (int k = 0; k < 40; k++) offer_pixel(PIX_W'($urandom_range(255)), 1'b0, NO_EDGE);

        // hold the output off so results back up and o_ready drops
        settle_block();
        write_reg(REG_FRAME_WIDTH, 13'd4);
        write_reg(REG_FRAME_HEIGHT, 13'd6);
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) begin
            if (k % 8 == 0) begin
                style = $urandom_range(2);
                base  = $urandom_range(255);
            end
            offer_pixel(pick_pixel(style, base), 1'b0, NO_EDGE);
        end

        for (int p = 0; p < 16; p++) begin
            settle_block();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            w_val = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(2))
                                             : CFG_W'($urandom_range(10, 3));
            h_val = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(2))
                                             : CFG_W'($urandom_range(7, 3));
            write_reg(REG_FRAME_WIDTH, w_val);
            if (p == 0 || $urandom_range(3) != 0) write_reg(REG_FRAME_HEIGHT, h_val);
            n_items = $urandom_range(35, 20);
            for (int k = 0; k < n_items; k++) begin
                if (k % 8 == 0) begin
                    style = $urandom_range(2);
                    base  = $urandom_range(255);
                end
                offer_pixel(pick_pixel(style, base), 1'b0, NO_EDGE);
            end
        end

        settle_block();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2500000;
        $display("timeout with %0d results still pending", pending_edges.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
